// File: design/rmtf_pkg.sv
// Shared types and constants for the recent-address move-to-front list.
// Used by rmtf_cell and recent_address_mtf_list; depends on nothing else.
`default_nettype none

package rmtf_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int OP_W   = 2;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int RIDX_W = 6;

  // Position and count fields in the cell command are sized for the largest capacity.
  localparam int POS_W      = 8;
  localparam int CNT_FULL_W = 9;

  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic                  shift_down;  // touch: cells up to pos take the entry above them
    logic                  shift_up;    // remove: cells from pos take the entry below them
    logic [POS_W-1:0]      pos;
    logic [CNT_FULL_W-1:0] count;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: design/rmtf_cell.sv
// One slot of the move-to-front chain: holds an address and port pair, compares it
// with the search key and trades entries with its neighbors. Depends on rmtf_pkg.
`default_nettype none

module rmtf_cell #(
  parameter int IDX = 0
) (
  input  wire                         clk,
  input  rmtf_pkg::cell_cmd_t         cmd,
  input  wire  [rmtf_pkg::IP_W-1:0]   key_ip,
  input  wire  [rmtf_pkg::PORT_W-1:0] key_port,
  input  wire  [rmtf_pkg::RIDX_W-1:0] read_index,
  input  wire  [rmtf_pkg::IP_W-1:0]   prev_ip,
  input  wire  [rmtf_pkg::PORT_W-1:0] prev_port,
  input  wire  [rmtf_pkg::IP_W-1:0]   next_ip,
  input  wire  [rmtf_pkg::PORT_W-1:0] next_port,
  output logic [rmtf_pkg::IP_W-1:0]   ip,
  output logic [rmtf_pkg::PORT_W-1:0] port,
  output logic                        hit,
  output logic [rmtf_pkg::IP_W-1:0]   rd_ip,
  output logic [rmtf_pkg::PORT_W-1:0] rd_port
);
  import rmtf_pkg::*;

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [IP_W-1:0]   ip_r;
  logic [IP_W-1:0]   ip_nxt;
  logic [PORT_W-1:0] port_r;
  logic [PORT_W-1:0] port_nxt;
  logic              filled;
  logic              read_sel;

  assign filled   = {1'b0, IDX_P} < cmd.count;
  assign hit      = filled && (ip_r == key_ip) && (port_r == key_port);
  assign read_sel = IDX_P == POS_W'(read_index);
  assign rd_ip    = read_sel ? ip_r : '0;
  assign rd_port  = read_sel ? port_r : '0;
  assign ip       = ip_r;
  assign port     = port_r;

  always_comb begin
    ip_nxt   = ip_r;
    port_nxt = port_r;
    if (cmd.shift_down && (IDX_P <= cmd.pos)) begin
      ip_nxt   = prev_ip;
      port_nxt = prev_port;
    end else if (cmd.shift_up && (IDX_P >= cmd.pos)) begin
      ip_nxt   = next_ip;
      port_nxt = next_port;
    end
  end

  always_ff @(posedge clk) begin
    ip_r   <= ip_nxt;
    port_r <= port_nxt;
  end

endmodule

`default_nettype wire

// File: design/recent_address_mtf_list.sv
// An accepted item passes through the compare state (match across all cells) and then the
// update state (shift update); its result strobe is registered in the update state. busy
// is high in the compare and update cycles, so a new item is taken only once the last is through.
// Reset (synchronous, active low) empties the list and clears the result strobe;
// slot contents are not cleared. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module recent_address_mtf_list #(
  parameter int CAPACITY = rmtf_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [rmtf_pkg::OP_W-1:0]   in_op,
  input  wire  [rmtf_pkg::IP_W-1:0]   in_addr_ip,
  input  wire  [rmtf_pkg::PORT_W-1:0] in_addr_port,
  input  wire  [rmtf_pkg::RIDX_W-1:0] in_read_index,
  output logic                        out_valid,
  output logic                        out_match_found,
  output logic [CNT_W-1:0]            out_entry_count,
  output logic                        out_entry_valid,
  output logic [rmtf_pkg::IP_W-1:0]   out_entry_ip,
  output logic [rmtf_pkg::PORT_W-1:0] out_entry_port
);
  import rmtf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  logic [IP_W-1:0]   key_ip_r;
  logic [PORT_W-1:0] key_port_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              found_r;
  logic [POS_W-1:0]  pos_r;
  logic              rd_valid_r;
  logic [IP_W-1:0]   rd_ip_r;
  logic [PORT_W-1:0] rd_port_r;
  logic              out_valid_r;
  logic              out_match_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_evalid_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;

  cell_cmd_t         cmd;
  logic [CAPACITY-1:0] hit;
  logic [IP_W-1:0]   cell_ip   [CAPACITY];
  logic [PORT_W-1:0] cell_port [CAPACITY];
  logic [IP_W-1:0]   cell_rd_ip   [CAPACITY];
  logic [PORT_W-1:0] cell_rd_port [CAPACITY];
  logic [POS_W-1:0]  pos_enc;
  logic [IP_W-1:0]   rd_ip_or;
  logic [PORT_W-1:0] rd_port_or;
  logic              is_touch;
  logic              is_remove;
  logic              is_read;

  assign is_touch  = op_r == OP_TOUCH;
  assign is_remove = op_r == OP_REMOVE;
  assign is_read   = op_r == OP_READ;

  // Cells only move in the update cycle; the count they see is the pre-item count.
  always_comb begin
    cmd.count      = CNT_FULL_W'(count_r);
    cmd.shift_down = (state_r == ST_UPD) && is_touch;
    cmd.shift_up   = (state_r == ST_UPD) && is_remove && found_r;
    cmd.pos        = found_r ? pos_r : POS_W'(CAPACITY - 1);
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rmtf_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .key_ip     (key_ip_r),
      .key_port   (key_port_r),
      .read_index (ridx_r),
      .prev_ip    ((g == 0) ? key_ip_r : cell_ip[(g == 0) ? 0 : g - 1]),
      .prev_port  ((g == 0) ? key_port_r : cell_port[(g == 0) ? 0 : g - 1]),
      .next_ip    (cell_ip[(g == CAPACITY - 1) ? g : g + 1]),
      .next_port  (cell_port[(g == CAPACITY - 1) ? g : g + 1]),
      .ip         (cell_ip[g]),
      .port       (cell_port[g]),
      .hit        (hit[g]),
      .rd_ip      (cell_rd_ip[g]),
      .rd_port    (cell_rd_port[g])
    );
  end

  // A pair is never stored twice, so at most one cell hits and an OR encodes its position.
  always_comb begin
    pos_enc    = '0;
    rd_ip_or   = '0;
    rd_port_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos_enc    = pos_enc | ({POS_W{hit[i]}} & POS_W'(i));
      rd_ip_or   = rd_ip_or | cell_rd_ip[i];
      rd_port_or = rd_port_or | cell_rd_port[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (is_touch && !found_r && (count_r != CNT_W'(CAPACITY))) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (is_remove && found_r) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          state_r     <= ST_IDLE;
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r       <= in_op;
      key_ip_r   <= in_addr_ip;
      key_port_r <= in_addr_port;
      ridx_r     <= in_read_index;
    end
    if (state_r == ST_CMP) begin
      found_r    <= |hit;
      pos_r      <= pos_enc;
      rd_valid_r <= {{(CNT_FULL_W - RIDX_W){1'b0}}, ridx_r} < CNT_FULL_W'(count_r);
      rd_ip_r    <= rd_ip_or;
      rd_port_r  <= rd_port_or;
    end
    if (state_r == ST_UPD) begin
      out_match_r  <= (is_touch || is_remove) && found_r;
      out_count_r  <= count_nxt;
      out_evalid_r <= is_read && rd_valid_r;
      out_ip_r     <= (is_read && rd_valid_r) ? rd_ip_r : '0;
      out_port_r   <= (is_read && rd_valid_r) ? rd_port_r : '0;
    end
  end

  assign busy            = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_match_found = out_match_r;
  assign out_entry_count = out_count_r;
  assign out_entry_valid = out_evalid_r;
  assign out_entry_ip    = out_ip_r;
  assign out_entry_port  = out_port_r;

`ifndef SYNTHESIS
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> $onehot0(hit))
    else $error("more than one cell holds the searched pair");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_UPD)
    else $error("result strobe without an update cycle");

  a_accept_to_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_CMP))
    else $error("accepted item did not enter the compare cycle");
`endif

endmodule

`default_nettype wire

// File: sim/recent_address_mtf_list_tb.sv
// Self-checking testbench for recent_address_mtf_list: a start/busy driver, a strobe monitor
// and a move-to-front list predictor that runs on every accepted item.
// Depends on rmtf_pkg and the recent_address_mtf_list RTL only.
`default_nettype none

module recent_address_mtf_list_tb;
  import rmtf_pkg::*;

  localparam int LIST_DEPTH = DEF_CAPACITY;
  localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int POOL_SIZE = 16;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [RIDX_W-1:0] ridx;
    logic [6:0]        gap_pct;
  } mtf_item_t;

  typedef struct packed {
    logic                match;
    logic [CNT_BITS-1:0] count;
    logic                valid;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
  } mtf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [OP_W-1:0]   in_op = '0;
  logic [IP_W-1:0]   in_addr_ip = '0;
  logic [PORT_W-1:0] in_addr_port = '0;
  logic [RIDX_W-1:0] in_read_index = '0;
  logic                busy;
  logic                out_valid;
  logic                out_match_found;
  logic [CNT_BITS-1:0] out_entry_count;
  logic                out_entry_valid;
  logic [IP_W-1:0]     out_entry_ip;
  logic [PORT_W-1:0]   out_entry_port;

  mtf_item_t   pending_items[$];
  mtf_result_t expected_results[$];
  int          mismatch_count = 0;

  // Predicted list contents, position 0 is the most recent entry.
  logic [IP_W-1:0]   list_ip[LIST_DEPTH];
  logic [PORT_W-1:0] list_port[LIST_DEPTH];
  int                list_fill = 0;

  logic [IP_W-1:0]   pool_ip[POOL_SIZE];
  logic [PORT_W-1:0] pool_port[POOL_SIZE];

  recent_address_mtf_list uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_addr_ip     (in_addr_ip),
    .in_addr_port   (in_addr_port),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_match_found(out_match_found),
    .out_entry_count(out_entry_count),
    .out_entry_valid(out_entry_valid),
    .out_entry_ip   (out_entry_ip),
    .out_entry_port (out_entry_port)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic mtf_result_t apply_to_list(mtf_item_t it);
    mtf_result_t r;
    int hit;
    r = '0;
    hit = -1;
    if (it.op == OP_TOUCH || it.op == OP_REMOVE) begin
      for (int i = 0; i < list_fill; i++) begin
        if (hit < 0 && list_ip[i] == it.ip && list_port[i] == it.port) hit = i;
      end
      if (hit >= 0) begin
        r.match = 1'b1;
        for (int i = hit; i < list_fill - 1; i++) begin
          list_ip[i]   = list_ip[i + 1];
          list_port[i] = list_port[i + 1];
        end
        list_fill--;
      end
      if (it.op == OP_TOUCH) begin
        // A new pair on a full list pushes the oldest entry out.
        if (list_fill >= LIST_DEPTH) list_fill = LIST_DEPTH - 1;
        for (int i = list_fill; i > 0; i--) begin
          list_ip[i]   = list_ip[i - 1];
          list_port[i] = list_port[i - 1];
        end
        list_ip[0]   = it.ip;
        list_port[0] = it.port;
        list_fill++;
      end
    end else if (it.op == OP_READ) begin
      if (it.ridx < list_fill) begin
        r.valid = 1'b1;
        r.ip    = list_ip[it.ridx];
        r.port  = list_port[it.ridx];
      end
    end
    r.count = CNT_BITS'(list_fill);
    return r;
  endfunction

  function automatic mtf_item_t make_item(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                                          logic [PORT_W-1:0] port, logic [RIDX_W-1:0] ridx,
                                          int gap);
    mtf_item_t it;
    it.op      = op;
    it.ip      = ip;
    it.port    = port;
    it.ridx    = ridx;
    it.gap_pct = 7'(gap);
    return it;
  endfunction

  task automatic queue_item(mtf_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Pairs come either from a small pool, so that touches and removes find matches,
  // or fresh from the random source, so that the list fills and overflows.
  task automatic add_random_items(int n, int gap, int fresh_pct, int remove_pct, int read_pct);
    int sel;
    int k;
    logic [OP_W-1:0]   op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    for (int j = 0; j < n; j++) begin
      sel = $urandom_range(99);
      if (sel < remove_pct) op = OP_REMOVE;
      else if (sel < remove_pct + read_pct) op = OP_READ;
      else if (sel < remove_pct + read_pct + 4) op = OP_UNUSED;
      else op = OP_TOUCH;
      if ($urandom_range(99) < fresh_pct) begin
        ip   = $urandom;
        port = PORT_W'($urandom);
      end else begin
        k    = $urandom_range(POOL_SIZE - 1);
        ip   = pool_ip[k];
        port = pool_port[k];
      end
      queue_item(make_item(op, ip, port, RIDX_W'($urandom_range(63)), gap));
    end
  endtask

  always @(posedge clk) begin : drive_items
    logic present;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), apply_to_list(pending_items[0]));
        void'(pending_items.pop_front());
        present = 1'b0;
      end
      if (!present && pending_items.size() != 0 &&
          $urandom_range(99) >= pending_items[0].gap_pct) begin
        present = 1'b1;
        in_op         <= pending_items[0].op;
        in_addr_ip    <= pending_items[0].ip;
        in_addr_port  <= pending_items[0].port;
        in_read_index <= pending_items[0].ridx;
      end
      start <= present;
    end
  end

  always @(posedge clk) begin : check_results
    mtf_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: match %0b count %0d valid %0b ip %h port %h",
                   out_match_found, out_entry_count, out_entry_valid, out_entry_ip,
                   out_entry_port);
      end else begin
        want = expected_results.pop_front();
        if (out_match_found !== want.match || out_entry_count !== want.count ||
            out_entry_valid !== want.valid || out_entry_ip !== want.ip ||
            out_entry_port !== want.port) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected match %0b count %0d valid %0b ip %h port %h",
                     want.match, want.count, want.valid, want.ip, want.port);
            $display("          actual   match %0b count %0d valid %0b ip %h port %h",
                     out_match_found, out_entry_count, out_entry_valid, out_entry_ip,
                     out_entry_port);
          end
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int k = 0; k < POOL_SIZE; k++) begin
      // Some neighbors in the pool share an address or a port so that equality needs both.
      pool_ip[k]   = (k % 4 == 1) ? pool_ip[k - 1] : $urandom;
      pool_port[k] = (k % 4 == 2) ? pool_port[k - 1] : PORT_W'($urandom);
    end

    // Empty list: reads, a remove and an ignored op.
    queue_item(make_item(OP_READ, '0, '0, 6'd0, 0));
    queue_item(make_item(OP_READ, '0, '0, 6'd63, 0));
    queue_item(make_item(OP_REMOVE, '0, '0, 6'd0, 0));
    queue_item(make_item(OP_UNUSED, '1, '1, 6'd63, 0));
    // Field extremes and pairs that differ in only one field, then reads, removes and an ignored op.
    queue_item(make_item(OP_TOUCH, '0, '0, 6'd0, 0));
    queue_item(make_item(OP_TOUCH, '1, '1, 6'd63, 0));
    queue_item(make_item(OP_TOUCH, '1, '0, 6'd0, 0));
    queue_item(make_item(OP_TOUCH, '0, '1, 6'd0, 0));
    queue_item(make_item(OP_TOUCH, '1, '1, 6'd0, 0));
    for (int i = 0; i < 5; i++)
      queue_item(make_item(OP_READ, '0, '0, RIDX_W'(i), 0));
    queue_item(make_item(OP_REMOVE, '0, '0, 6'd0, 0));
    queue_item(make_item(OP_REMOVE, 32'hC0A8_0001, 16'h1234, 6'd0, 0));
    queue_item(make_item(OP_REMOVE, '1, '0, 6'd0, 0));
    queue_item(make_item(OP_UNUSED, '1, '1, 6'd0, 0));
    queue_item(make_item(OP_READ, '0, '0, 6'd0, 0));
    queue_item(make_item(OP_READ, '0, '0, 6'd1, 0));
    queue_item(make_item(OP_READ, '0, '0, 6'd63, 0));
    queue_item(make_item(OP_TOUCH, '0, '0, 6'd0, 0));

    add_random_items(200, 0, 10, 20, 30);
    add_random_items(200, 48, 60, 10, 25);
    add_random_items(200, 0, 35, 35, 30);
    add_random_items(200, 29, 20, 20, 30);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
